// ----- rtl/char_lcd_nibble_write_sequencer_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define LCDN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define LCDN_NEVER(lbl, clk, rst_n, cond, msg) \
    `LCDN_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- rtl/lcdn_pkg.sv -----
`default_nettype none

package lcdn_pkg;

    localparam int CPM_W  = 20;
    localparam int HOLD_W = 6;
    localparam int STEP_W = 5;

    localparam logic [CPM_W-1:0] CPM_RESET = 20'd8000;

    // Item kinds
    localparam logic [2:0] KIND_INSTR  = 3'd0;
    localparam logic [2:0] KIND_DATA   = 3'd1;
    localparam logic [2:0] KIND_CURSOR = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_INIT   = 3'd4;

    // Set DDRAM address command and line base addresses
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] LINE1_BASE   = 8'h00;
    localparam logic [7:0] LINE2_BASE   = 8'h40;
    localparam logic [7:0] LINE3_BASE   = 8'h14;
    localparam logic [7:0] LINE4_BASE   = 8'h54;

    // Init sequence bytes
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0c;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;

    // Program entry points
    localparam logic [STEP_W-1:0] STEP_ITEM  = 5'd0;
    localparam logic [STEP_W-1:0] STEP_INIT  = 5'd4;
    localparam logic [STEP_W-1:0] STEP_CLEAR = 5'd17;

    typedef enum logic [1:0] {
        OP_NEXT,
        OP_END,
        OP_END_UNLESS_INIT
    } ucode_op_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EMIT,
        SEQ_WAIT
    } seq_state_t;

    typedef struct packed {
        logic              use_item;    // 1: latched item byte, 0: const_byte
        logic [7:0]        const_byte;
        logic              hi_nib;
        logic              en;
        logic [HOLD_W-1:0] hold;
        ucode_op_t         op;
    } ucode_word_t;

    typedef struct packed {
        logic busy;
        logic emit;
        logic last;
    } seq_status_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [2:0] line;
        logic [7:0] cell_req;
    } lcd_item_t;

    typedef struct packed {
        logic              reg_select;
        logic [3:0]        bus_nibble;
        logic              enable;
        logic [HOLD_W-1:0] hold_ms;
        logic              last;
    } lcd_phase_t;

    function automatic ucode_word_t uw(input logic use_item, input logic [7:0] b,
                                       input logic hi, input logic en,
                                       input logic [HOLD_W-1:0] hold, input ucode_op_t op);
        ucode_word_t w;
        w.use_item   = use_item;
        w.const_byte = b;
        w.hi_nib     = hi;
        w.en         = en;
        w.hold       = hold;
        w.op         = op;
        return w;
    endfunction

    // Control program: four phases per byte (hi EN high, hi EN low, lo EN high, lo EN low).
    function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_word_t w;
        case (step)
            5'd0:    w = uw(1'b1, 8'h00,        1'b1, 1'b1, 6'd1,  OP_NEXT);
            5'd1:    w = uw(1'b1, 8'h00,        1'b1, 1'b0, 6'd1,  OP_NEXT);
            5'd2:    w = uw(1'b1, 8'h00,        1'b0, 1'b1, 6'd1,  OP_NEXT);
            5'd3:    w = uw(1'b1, 8'h00,        1'b0, 1'b0, 6'd1,  OP_END);
            5'd4:    w = uw(1'b0, 8'h00,        1'b1, 1'b0, 6'd50, OP_NEXT);
            5'd5:    w = uw(1'b0, CMD_HOME,     1'b1, 1'b1, 6'd1,  OP_NEXT);
            5'd6:    w = uw(1'b0, CMD_HOME,     1'b1, 1'b0, 6'd1,  OP_NEXT);
            5'd7:    w = uw(1'b0, CMD_HOME,     1'b0, 1'b1, 6'd1,  OP_NEXT);
            5'd8:    w = uw(1'b0, CMD_HOME,     1'b0, 1'b0, 6'd1,  OP_NEXT);
            5'd9:    w = uw(1'b0, CMD_FUNC_SET, 1'b1, 1'b1, 6'd1,  OP_NEXT);
            5'd10:   w = uw(1'b0, CMD_FUNC_SET, 1'b1, 1'b0, 6'd1,  OP_NEXT);
            5'd11:   w = uw(1'b0, CMD_FUNC_SET, 1'b0, 1'b1, 6'd1,  OP_NEXT);
            5'd12:   w = uw(1'b0, CMD_FUNC_SET, 1'b0, 1'b0, 6'd1,  OP_NEXT);
            5'd13:   w = uw(1'b0, CMD_DISP_ON,  1'b1, 1'b1, 6'd1,  OP_NEXT);
            5'd14:   w = uw(1'b0, CMD_DISP_ON,  1'b1, 1'b0, 6'd1,  OP_NEXT);
            5'd15:   w = uw(1'b0, CMD_DISP_ON,  1'b0, 1'b1, 6'd1,  OP_NEXT);
            5'd16:   w = uw(1'b0, CMD_DISP_ON,  1'b0, 1'b0, 6'd1,  OP_NEXT);
            5'd17:   w = uw(1'b0, CMD_CLEAR,    1'b1, 1'b1, 6'd1,  OP_NEXT);
            5'd18:   w = uw(1'b0, CMD_CLEAR,    1'b1, 1'b0, 6'd1,  OP_NEXT);
            5'd19:   w = uw(1'b0, CMD_CLEAR,    1'b0, 1'b1, 6'd1,  OP_NEXT);
            5'd20:   w = uw(1'b0, CMD_CLEAR,    1'b0, 1'b0, 6'd2,  OP_END_UNLESS_INIT);
            5'd21:   w = uw(1'b0, CMD_ENTRY,    1'b1, 1'b1, 6'd1,  OP_NEXT);
            5'd22:   w = uw(1'b0, CMD_ENTRY,    1'b1, 1'b0, 6'd1,  OP_NEXT);
            5'd23:   w = uw(1'b0, CMD_ENTRY,    1'b0, 1'b1, 6'd1,  OP_NEXT);
            5'd24:   w = uw(1'b0, CMD_ENTRY,    1'b0, 1'b0, 6'd1,  OP_END);
            default: w = uw(1'b0, 8'h00,        1'b0, 1'b0, 6'd1,  OP_END);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lcdn_hold_timer.sv -----
`default_nettype none

module lcdn_hold_timer
    import lcdn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic [HOLD_W-1:0] hold,
    input  wire logic [CPM_W-1:0]  cpm,
    output logic                   done
);

    logic              active_reg, active_next;
    logic [HOLD_W-1:0] ms_left_reg, ms_left_next;
    logic [CPM_W-1:0]  cyc_reg, cyc_next;
    logic              ms_tick;
    logic              final_ms;

    // Millisecond tick when the cycle count reaches the programmed length.
    assign ms_tick  = ({1'b0, cyc_reg} + {{CPM_W{1'b0}}, 1'b1}) >= {1'b0, cpm};
    assign final_ms = (ms_left_reg <= HOLD_W'(1));
    assign done     = active_reg && ms_tick && final_ms;

    always_comb
    begin
        active_next  = active_reg;
        ms_left_next = ms_left_reg;
        cyc_next     = cyc_reg;
        if (load)
        begin
            active_next  = 1'b1;
            ms_left_next = hold;
            cyc_next     = '0;
        end
        else if (active_reg)
        begin
            if (ms_tick)
            begin
                cyc_next = '0;
                if (final_ms)
                    active_next = 1'b0;
                else
                    ms_left_next = ms_left_reg - HOLD_W'(1);
            end
            else
            begin
                cyc_next = cyc_reg + CPM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ms_left_reg <= ms_left_next;
        cyc_reg     <= cyc_next;
    end

endmodule

`default_nettype wire

// ----- rtl/lcdn_sequencer.sv -----
`default_nettype none

module lcdn_sequencer
    import lcdn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [2:0]  kind,
    input  wire logic        phase_done,
    output ucode_word_t      ctrl,
    output seq_status_t      status
);

    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              init_reg, init_next;
    logic              finish;
    logic [STEP_W-1:0] entry;

    assign ctrl = ucode_rom(step_reg);

    // Conditional end: the clear routine continues into the entry-mode byte during init.
    always_comb
    begin
        case (ctrl.op)
            OP_END:             finish = 1'b1;
            OP_END_UNLESS_INIT: finish = !init_reg;
            default:            finish = 1'b0;
        endcase
    end

    always_comb
    begin
        if (kind == KIND_INIT)
            entry = STEP_INIT;
        else if (kind == KIND_CLEAR)
            entry = STEP_CLEAR;
        else
            entry = STEP_ITEM;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        init_next  = init_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (go)
                begin
                    state_next = SEQ_EMIT;
                    step_next  = entry;
                    init_next  = (kind == KIND_INIT);
                end
            end
            SEQ_EMIT:
            begin
                state_next = SEQ_WAIT;
            end
            SEQ_WAIT:
            begin
                if (phase_done)
                begin
                    if (finish)
                    begin
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        state_next = SEQ_EMIT;
                        step_next  = step_reg + STEP_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        status.busy = (state_reg != SEQ_IDLE);
        status.emit = (state_reg == SEQ_EMIT);
        status.last = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            step_reg  <= '0;
            init_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            init_reg  <= init_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/char_lcd_nibble_write_sequencer.sv -----
`default_nettype none

// Character LCD write sequencer for a 4-bit HD44780-style bus. Pulse start while
// busy is low to hand over one item: an instruction byte, a data byte, a cursor
// move (line 1 to 4 plus column), a clear or the power-up init. The block then
// walks a small control program and reports every pin phase as one result on
// the result port, marked by a single-cycle strobe at the moment the pins take
// that state; the receiver cannot stall, so sample every strobe. Each byte goes
// out as four phases (high nibble EN high, EN low, low nibble EN high, EN low),
// each held hold_ms milliseconds, with last set on the item's final phase. A
// cursor move to an invalid line and an unknown kind are taken but produce no
// result. Each phase is counted by the millisecond hold timer, so a byte item
// takes about 4 ms, a clear 5 ms and an init 71 ms; busy stays high for that
// whole time. cfg_data written with cfg_we sets cycles_per_millisecond (reset
// 8000); write it only while idle.
module char_lcd_nibble_write_sequencer
    import lcdn_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire lcd_item_t        item,
    output logic                  strobe,
    output lcd_phase_t            result,
    input  wire logic             cfg_we,
    input  wire logic [CPM_W-1:0] cfg_data
);

    logic [CPM_W-1:0] cpm_reg;
    logic [7:0]       byte_reg, byte_next;
    logic             rs_reg, rs_next;
    lcd_phase_t       result_reg, result_next;
    logic             strobe_reg;

    ucode_word_t      ctrl;
    seq_status_t      status;
    logic             phase_done;
    logic             accept;
    logic             item_ok;
    logic [7:0]       line_base;
    logic             line_ok;
    logic [7:0]       src_byte;

    assign accept = start && !status.busy;
    assign busy   = status.busy;
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Line base address for the cursor move; lines outside 1..4 are dropped.
    always_comb
    begin
        line_ok   = 1'b1;
        line_base = LINE1_BASE;
        case (item.line)
            3'd1:    line_base = LINE1_BASE;
            3'd2:    line_base = LINE2_BASE;
            3'd3:    line_base = LINE3_BASE;
            3'd4:    line_base = LINE4_BASE;
            default: line_ok   = 1'b0;
        endcase
    end

    // Latch the byte and RS level that the item-byte routine sends.
    always_comb
    begin
        item_ok   = 1'b0;
        byte_next = byte_reg;
        rs_next   = rs_reg;
        if (item.kind inside {KIND_INSTR, KIND_DATA})
        begin
            item_ok   = 1'b1;
            byte_next = item.value;
            rs_next   = (item.kind == KIND_DATA);
        end
        else if (item.kind == KIND_CURSOR)
        begin
            item_ok   = line_ok;
            byte_next = CMD_SET_ADDR + line_base + item.cell_req;
            rs_next   = 1'b0;
        end
        else if (item.kind inside {KIND_CLEAR, KIND_INIT})
        begin
            item_ok = 1'b1;
            rs_next = 1'b0;
        end
    end

    lcdn_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (accept && item_ok),
        .kind       (item.kind),
        .phase_done (phase_done),
        .ctrl       (ctrl),
        .status     (status)
    );

    lcdn_hold_timer u_timer (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (status.emit),
        .hold  (ctrl.hold),
        .cpm   (cpm_reg),
        .done  (phase_done)
    );

    // Datapath: pick the byte source and nibble the control word asks for.
    assign src_byte = ctrl.use_item ? byte_reg : ctrl.const_byte;

    always_comb
    begin
        result_next            = result_reg;
        if (status.emit)
        begin
            result_next.reg_select = rs_reg;
            result_next.bus_nibble = ctrl.hi_nib ? src_byte[7:4] : src_byte[3:0];
            result_next.enable     = ctrl.en;
            result_next.hold_ms    = ctrl.hold;
            result_next.last       = status.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpm_reg    <= CPM_RESET;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cpm_reg <= cfg_data;
            strobe_reg <= status.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            byte_reg <= byte_next;
            rs_reg   <= rs_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lcdn_checker.sv -----
`default_nettype none

`include "char_lcd_nibble_write_sequencer_macros.svh"

module lcdn_checker
    import lcdn_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             busy,
    input  wire logic             strobe,
    input  wire lcd_phase_t       result
);

    // Results only come out while an item is in progress.
    `LCDN_ASSERT(a_strobe_busy, clk, rst_n, strobe |-> busy, "result outside an item")

    // Two phase strobes never come back to back.
    `LCDN_ASSERT(a_strobe_gap, clk, rst_n, strobe |=> !strobe, "back-to-back phases")

    // EN high phases are always one millisecond.
    `LCDN_ASSERT(a_en_hold, clk, rst_n, (strobe && result.enable) |-> (result.hold_ms == 6'd1), "EN high not 1 ms")

    // Every phase holds for some time.
    `LCDN_NEVER(a_zero_hold, clk, rst_n, strobe && (result.hold_ms == 6'd0), "zero hold")

endmodule

bind char_lcd_nibble_write_sequencer lcdn_checker u_lcdn_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the 4-bit character LCD write sequencer.
// A queue of pending items feeds a clocked driver. The driver works out the
// expected pin phases of every item at the edge where the block takes it.
// A clocked monitor pops the oldest expected phase on every strobe and
// compares it field by field.
module testbench;
    import lcdn_pkg::*;

    // Hold lengths in milliseconds, as reported on the result port
    localparam logic [HOLD_W-1:0] HOLD_NIBBLE  = 6'd1;
    localparam logic [HOLD_W-1:0] HOLD_CLEAR   = 6'd2;
    localparam logic [HOLD_W-1:0] HOLD_POWERUP = 6'd50;

    // Kind codes the block takes but ignores
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam logic [CPM_W-1:0] CPM_MIN = 20'd1;
    localparam logic [CPM_W-1:0] CPM_MAX = 20'd1000000;

    // Quiet cycles before a register write and before the final verdict
    localparam int SETTLE_CYCLES = 16;

    // One pending item; drain holds it back until all expected phases are in
    typedef struct packed {
        logic      drain;
        lcd_item_t it;
    } lcd_cmd_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             start    = 1'b0;
    lcd_item_t        item     = '0;
    logic             cfg_we   = 1'b0;
    logic [CPM_W-1:0] cfg_data = CPM_RESET;
    logic             busy;
    logic             strobe;
    lcd_phase_t       result;

    lcd_cmd_t         pending_items[$];
    lcd_phase_t       expected_phases[$];
    int               idle_pct   = 32;
    int               errors     = 0;

    char_lcd_nibble_write_sequencer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .strobe   (strobe),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pin phase predictor
    // ------------------------------------------------------------------

    function automatic void add_phase(input logic rs, input logic [3:0] nib,
                                      input logic en, input logic [HOLD_W-1:0] hold);
        lcd_phase_t p;
        p.reg_select = rs;
        p.bus_nibble = nib;
        p.enable     = en;
        p.hold_ms    = hold;
        p.last       = 1'b0;
        expected_phases.push_back(p);
    endfunction

    // Send a byte high nibble first, each nibble as an EN high then EN low phase.
    function automatic void add_byte(input logic rs, input logic [7:0] b,
                                     input logic [HOLD_W-1:0] final_hold);
        add_phase(rs, b[7:4], 1'b1, HOLD_NIBBLE);
        add_phase(rs, b[7:4], 1'b0, HOLD_NIBBLE);
        add_phase(rs, b[3:0], 1'b1, HOLD_NIBBLE);
        add_phase(rs, b[3:0], 1'b0, final_hold);
    endfunction

    function automatic void predict_phases(input lcd_item_t it);
        int         phases_before;
        logic       line_ok;
        logic [7:0] base;
        lcd_phase_t tail;
        phases_before = expected_phases.size();
        line_ok       = 1'b1;
        base          = LINE1_BASE;
        case (it.kind)
            KIND_INSTR: add_byte(1'b0, it.value, HOLD_NIBBLE);
            KIND_DATA:  add_byte(1'b1, it.value, HOLD_NIBBLE);
            KIND_CURSOR:
            begin
                case (it.line)
                    3'd1:    base = LINE1_BASE;
                    3'd2:    base = LINE2_BASE;
                    3'd3:    base = LINE3_BASE;
                    3'd4:    base = LINE4_BASE;
                    default: line_ok = 1'b0;
                endcase
                // The address wraps to 8 bits; an invalid line sends nothing.
                if (line_ok)
                    add_byte(1'b0, CMD_SET_ADDR + base + it.cell_req, HOLD_NIBBLE);
            end
            KIND_CLEAR: add_byte(1'b0, CMD_CLEAR, HOLD_CLEAR);
            KIND_INIT:
            begin
                add_phase(1'b0, 4'h0, 1'b0, HOLD_POWERUP);
                add_byte(1'b0, CMD_HOME,     HOLD_NIBBLE);
                add_byte(1'b0, CMD_FUNC_SET, HOLD_NIBBLE);
                add_byte(1'b0, CMD_DISP_ON,  HOLD_NIBBLE);
                add_byte(1'b0, CMD_CLEAR,    HOLD_CLEAR);
                add_byte(1'b0, CMD_ENTRY,    HOLD_NIBBLE);
            end
            default: ;
        endcase
        // Mark the final phase of this item.
        if (expected_phases.size() > phases_before)
        begin
            tail      = expected_phases.pop_back();
            tail.last = 1'b1;
            expected_phases.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer the head of the pending queue, idle at random
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : item_driver
        lcd_cmd_t head;
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            // The block takes the item at this edge: predict its phases now.
            if (start && !busy)
                predict_phases(item);
            // Pick what to offer next once the current slot is free.
            if (!start || !busy)
            begin
                if (pending_items.size() > 0)
                    head = pending_items[0];
                else
                    head = '0;
                if (pending_items.size() > 0
                    && !(head.drain && expected_phases.size() > 0)
                    && $urandom_range(99) >= idle_pct)
                begin
                    item  <= head.it;
                    start <= 1'b1;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe is one phase, compare against the oldest
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : phase_monitor
        lcd_phase_t want;
        if (rst_n && strobe)
        begin
            if (expected_phases.size() == 0)
            begin
                $display("%0t: unexpected phase: expected none, actual %h", $time, result);
                errors++;
            end
            else
            begin
                want = expected_phases.pop_front();
                check_field("reg_select", 8'(want.reg_select), 8'(result.reg_select));
                check_field("bus_nibble", 8'(want.bus_nibble), 8'(result.bus_nibble));
                check_field("enable",     8'(want.enable),     8'(result.enable));
                check_field("hold_ms",    8'(want.hold_ms),    8'(result.hold_ms));
                check_field("last",       8'(want.last),       8'(result.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_item(input logic [2:0] kind, input logic [7:0] value,
                              input logic [2:0] line, input logic [7:0] column,
                              input logic drain);
        lcd_cmd_t c;
        c.drain       = drain;
        c.it.kind     = kind;
        c.it.value    = value;
        c.it.line     = line;
        c.it.cell_req = column;
        pending_items.push_back(c);
    endtask

    // Wait until every item is taken, every phase has come and busy has dropped;
    // an item with no phases may still be in flight, so let it settle too.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || start || expected_phases.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cpm(input logic [CPM_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic lcd_item_t random_item();
        lcd_item_t it;
        int        pick;
        it.value    = 8'($urandom);
        it.line     = 3'($urandom);
        it.cell_req = 8'($urandom);
        pick        = int'($urandom_range(99));
        if (pick < 25)
            it.kind = KIND_INSTR;
        else if (pick < 50)
            it.kind = KIND_DATA;
        else if (pick < 76)
        begin
            it.kind = KIND_CURSOR;
            // Steer most moves to a real line; keep a few invalid ones.
            if ($urandom_range(9) != 0)
                it.line = 3'($urandom_range(4, 1));
        end
        else if (pick < 88)
            it.kind = KIND_CLEAR;
        else if (pick < 95)
            it.kind = KIND_INIT;
        else
            it.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        return it;
    endfunction

    initial
    begin : stimulus
        logic [CPM_W-1:0] cpm_plan [4];
        lcd_item_t        it;
        int               counted;
        cpm_plan = '{20'd3, 20'd1, 20'd2, 20'd5};

        // Hold reset, then release it once for the whole run.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Run one data byte at the reset millisecond setting.
        queue_item(KIND_DATA, 8'hA5, 3'($urandom), 8'($urandom), 1'b0);
        wait_quiet();

        // Set the largest millisecond and send only items that make no phase.
        write_cpm(CPM_MAX);
        queue_item(KIND_CURSOR, 8'($urandom), 3'd0, 8'($urandom), 1'b0);
        queue_item(KIND_SPARE_LO, 8'($urandom), 3'($urandom), 8'($urandom), 1'b0);
        wait_quiet();

        // Drop to the CPM_MIN millisecond setting for the directed part.
        write_cpm(CPM_MIN);
        queue_item(KIND_INSTR,  8'h00, 3'd7, 8'hFF, 1'b0);
        queue_item(KIND_INSTR,  8'hFF, 3'd0, 8'h00, 1'b0);
        queue_item(KIND_DATA,   8'h00, 3'd0, 8'h00, 1'b0);
        queue_item(KIND_DATA,   8'hFF, 3'd7, 8'hFF, 1'b0);
        queue_item(KIND_CURSOR, 8'($urandom), 3'd1, 8'h00, 1'b0);
        queue_item(KIND_CURSOR, 8'($urandom), 3'd2, 8'hFF, 1'b0);
        queue_item(KIND_CURSOR, 8'($urandom), 3'd3, 8'h7F, 1'b0);
        // line 4 with a column that carries the address past 8 bits
        queue_item(KIND_CURSOR, 8'($urandom), 3'd4, 8'hAC, 1'b0);
        queue_item(KIND_CURSOR, 8'($urandom), 3'd0, 8'($urandom), 1'b0);
        queue_item(KIND_CURSOR, 8'($urandom), 3'd5, 8'($urandom), 1'b0);
        queue_item(KIND_CURSOR, 8'($urandom), 3'd7, 8'($urandom), 1'b0);
        queue_item(KIND_CLEAR,  8'($urandom), 3'($urandom), 8'($urandom), 1'b0);
        queue_item(KIND_INIT,   8'($urandom), 3'($urandom), 8'($urandom), 1'b0);
        queue_item(KIND_SPARE_LO, 8'($urandom), 3'($urandom), 8'($urandom), 1'b0);
        queue_item(KIND_SPARE_HI, 8'($urandom), 3'($urandom), 8'($urandom), 1'b0);
        // Drain before this init so the sender sits idle behind the block.
        queue_item(KIND_INIT,   8'($urandom), 3'($urandom), 8'($urandom), 1'b1);
        queue_item(KIND_CLEAR,  8'($urandom), 3'($urandom), 8'($urandom), 1'b0);
        queue_item(KIND_DATA,   8'h5A, 3'($urandom), 8'($urandom), 1'b0);
        wait_quiet();

        // Random part: four runs of 20 phase-making items at small settings;
        // the third run never idles the sender.
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            write_cpm(cpm_plan[chunk]);
            idle_pct = (chunk == 2) ? 0 : 32;
            counted  = 0;
            while (counted < 20)
            begin
                it = random_item();
                queue_item(it.kind, it.value, it.line, it.cell_req,
                           $urandom_range(19) == 0);
                if (it.kind <= KIND_INIT
                    && !(it.kind == KIND_CURSOR && (it.line == 3'd0 || it.line > 3'd4)))
                    counted++;
            end
            wait_quiet();
        end

        if (errors == 0 && expected_phases.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stop a hung run; the slowest correct run is well under a tenth of this.
    initial
    begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- char_lcd_nibble_write_sequencer.f -----
+incdir+rtl
rtl/lcdn_pkg.sv
rtl/lcdn_hold_timer.sv
rtl/lcdn_sequencer.sv
rtl/char_lcd_nibble_write_sequencer.sv
rtl/lcdn_checker.sv
dv/testbench.sv
